@@ rtl/dtvl_pkg.sv @@
// Shared types and constants for the differential thrust velocity loop.
`timescale 1ns / 1ps

package dtvl_pkg;

  // Divider lanes: 15 quotient bits, operands up to 23 bits.
  localparam int Q_W = 15;
  localparam int MAG_W = 23;
  localparam int DIV_CNT_W = $clog2(Q_W);

  // Base thrust integrator limits (Q4.14, plus or minus 4.0).
  localparam logic signed [17:0] BASE_MAX = 18'sd65536;
  localparam logic signed [17:0] BASE_MIN = -18'sd65536;

  // Unit thrust (1.0 in Q2.14) as a magnitude.
  localparam logic [MAG_W-1:0] UNIT_MAG = 23'd16384;

  // Configuration register indexes.
  localparam logic [2:0] REG_SURGE_VEL_LIMIT = 3'd0;
  localparam logic [2:0] REG_YAW_VEL_LIMIT = 3'd1;
  localparam logic [2:0] REG_SURGE_CLAMP = 3'd2;
  localparam logic [2:0] REG_YAW_CLAMP = 3'd3;
  localparam logic [2:0] REG_SURGE_GAIN = 3'd4;
  localparam logic [2:0] REG_YAW_GAIN = 3'd5;

  // Configuration register contents.
  typedef struct packed {
    logic [15:0] surge_vel_limit;
    logic [15:0] yaw_vel_limit;
    logic [14:0] surge_clamp;
    logic [14:0] yaw_clamp;
    logic [15:0] surge_gain;
    logic [15:0] yaw_gain;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic norm_init;
    logic resc_init;
    logic div_step;
    logic norm_fin;
    logic mul_surge;
    logic mul_yaw;
    logic base_upd;
    logic mix;
    logic mag;
    logic pick_max;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic resc_now;
  } status_t;

endpackage

@@ rtl/dtvl_div_lane.sv @@
// Restoring divider lane producing a 15-bit quotient of (mag * 2^14) / divisor.
`timescale 1ns / 1ps

module dtvl_div_lane (
  input  logic                           clk,
  input  logic                           init,
  input  logic                           step,
  input  logic [dtvl_pkg::MAG_W-1:0]     dividend_mag,
  input  logic [dtvl_pkg::MAG_W-1:0]     divisor,
  output logic [dtvl_pkg::Q_W-1:0]       quotient
);

  logic [dtvl_pkg::MAG_W-1:0] rem;
  logic [dtvl_pkg::Q_W-1:0]   bits;
  logic [dtvl_pkg::MAG_W-1:0] d;
  logic [dtvl_pkg::Q_W-1:0]   q;
  logic [dtvl_pkg::MAG_W:0]   trial;
  logic                       ge;

  // One quotient bit per step: shift in the next dividend bit and compare.
  assign trial = {rem, bits[dtvl_pkg::Q_W-1]};
  assign ge = trial >= {1'b0, d};

  // The partial remainder starts at mag / 2, which is below the divisor
  // whenever the quotient fits in 15 bits.
  always_ff @(posedge clk) begin
    if (init) begin
      rem <= {1'b0, dividend_mag[dtvl_pkg::MAG_W-1:1]};
      bits <= {dividend_mag[0], {(dtvl_pkg::Q_W-1){1'b0}}};
      d <= divisor;
      q <= '0;
    end else if (step) begin
      rem <= ge ? dtvl_pkg::MAG_W'(trial - {1'b0, d}) : trial[dtvl_pkg::MAG_W-1:0];
      bits <= {bits[dtvl_pkg::Q_W-2:0], 1'b0};
      q <= {q[dtvl_pkg::Q_W-2:0], ge};
    end
  end

  assign quotient = q;

endmodule

@@ rtl/dtvl_datapath.sv @@
// Datapath: error normalization, base integrator, thrust mixing and rescaling.
`timescale 1ns / 1ps

module dtvl_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  dtvl_pkg::cfg_t          cfg,
  input  dtvl_pkg::cmd_t          cmd,
  output dtvl_pkg::status_t       status,
  input  logic signed [15:0]      target_surge,
  input  logic signed [15:0]      measured_surge,
  input  logic signed [15:0]      target_yaw,
  input  logic signed [15:0]      measured_yaw,
  output logic signed [15:0]      left_thrust,
  output logic signed [15:0]      right_thrust,
  output logic                    base_saturated,
  output logic                    rescaled
);

  localparam int MW = dtvl_pkg::MAG_W;
  localparam int QW = dtvl_pkg::Q_W;

  function automatic logic [16:0] abs17(input logic signed [16:0] v);
    return v[16] ? 17'(-v) : 17'(v);
  endfunction

  function automatic logic [24:0] abs25(input logic signed [24:0] v);
    return v[24] ? 25'(-v) : 25'(v);
  endfunction

  logic signed [16:0] err_s;
  logic signed [16:0] err_y;
  logic [16:0]        mag_es;
  logic [16:0]        mag_ey;
  logic               ovf_s;
  logic               ovf_y;
  logic signed [15:0] ns;
  logic signed [15:0] ny;
  logic [QW-1:0]      qs_s;
  logic [QW-1:0]      qs_y;
  logic signed [16:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [32:0] prod;
  logic signed [24:0] step_v;
  logic signed [23:0] diff;
  logic signed [25:0] sum;
  logic signed [25:0] base_next;
  logic signed [17:0] base;
  logic               sat;
  logic signed [24:0] left;
  logic signed [24:0] right;
  logic [24:0]        abs_l;
  logic [24:0]        abs_r;
  logic [MW-1:0]      mag_l;
  logic [MW-1:0]      mag_r;
  logic [MW-1:0]      m;
  logic               resc;
  logic [MW-1:0]      div_a_num;
  logic [MW-1:0]      div_a_den;
  logic [MW-1:0]      div_b_num;
  logic [MW-1:0]      div_b_den;
  logic [QW-1:0]      q_a;
  logic [QW-1:0]      q_b;

  assign mag_es = abs17(err_s);
  assign mag_ey = abs17(err_y);

  // Divider operands: normalization of both errors, then rescaling of both thrusts.
  always_comb begin
    if (cmd.resc_init) begin
      div_a_num = mag_l;
      div_a_den = m;
      div_b_num = mag_r;
      div_b_den = m;
    end else begin
      div_a_num = MW'(mag_es);
      div_a_den = MW'(cfg.surge_vel_limit);
      div_b_num = MW'(mag_ey);
      div_b_den = MW'(cfg.yaw_vel_limit);
    end
  end

  dtvl_div_lane u_div_a (
    .clk          (clk),
    .init         (cmd.norm_init | cmd.resc_init),
    .step         (cmd.div_step),
    .dividend_mag (div_a_num),
    .divisor      (div_a_den),
    .quotient     (q_a)
  );

  dtvl_div_lane u_div_b (
    .clk          (clk),
    .init         (cmd.norm_init | cmd.resc_init),
    .step         (cmd.div_step),
    .dividend_mag (div_b_num),
    .divisor      (div_b_den),
    .quotient     (q_b)
  );

  // Clamped quotient magnitudes; an overflowed or zero-limit quotient takes the clamp.
  // A zero error always normalizes to zero, even with a zero limit.
  assign qs_s = (mag_es == '0) ? '0 :
                ((ovf_s || (q_a > cfg.surge_clamp)) ? cfg.surge_clamp : q_a);
  assign qs_y = (mag_ey == '0) ? '0 :
                ((ovf_y || (q_b > cfg.yaw_clamp)) ? cfg.yaw_clamp : q_b);

  // Shared multiplier operands.
  always_comb begin
    if (cmd.mul_yaw) begin
      mul_a = $signed({1'b0, cfg.yaw_gain});
      mul_b = ny;
    end else begin
      mul_a = $signed({1'b0, cfg.surge_gain});
      mul_b = ns;
    end
  end

  // Base integrator update with saturation at plus or minus 4.0.
  assign step_v = prod[32:8];
  assign sum = 26'(base) + 26'(step_v);
  always_comb begin
    if (sum > 26'(dtvl_pkg::BASE_MAX)) begin
      base_next = 26'(dtvl_pkg::BASE_MAX);
    end else if (sum < 26'(dtvl_pkg::BASE_MIN)) begin
      base_next = 26'(dtvl_pkg::BASE_MIN);
    end else begin
      base_next = sum;
    end
  end

  assign diff = prod[32:9];
  assign abs_l = abs25(left);
  assign abs_r = abs25(right);
  assign status.resc_now = (mag_l > dtvl_pkg::UNIT_MAG) || (mag_r > dtvl_pkg::UNIT_MAG);

  // Integrator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (cmd.base_upd) begin
      base <= base_next[17:0];
    end
  end

  // Working registers of one transaction.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      err_s <= 17'(target_surge) - 17'(measured_surge);
      err_y <= 17'(target_yaw) - 17'(measured_yaw);
    end
    if (cmd.norm_init) begin
      ovf_s <= (mag_es >= {cfg.surge_vel_limit, 1'b0}) && (mag_es != '0);
      ovf_y <= (mag_ey >= {cfg.yaw_vel_limit, 1'b0}) && (mag_ey != '0);
    end
    if (cmd.norm_fin) begin
      ns <= err_s[16] ? 16'(-{1'b0, qs_s}) : {1'b0, qs_s};
      ny <= err_y[16] ? 16'(-{1'b0, qs_y}) : {1'b0, qs_y};
    end
    if (cmd.mul_surge || cmd.mul_yaw) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.base_upd) begin
      sat <= (base_next == 26'(dtvl_pkg::BASE_MAX)) || (base_next == 26'(dtvl_pkg::BASE_MIN));
    end
    if (cmd.mix) begin
      left <= 25'(base) + 25'(diff);
      right <= 25'(base) - 25'(diff);
    end
    if (cmd.mag) begin
      mag_l <= abs_l[MW-1:0];
      mag_r <= abs_r[MW-1:0];
    end
    if (cmd.pick_max) begin
      m <= (mag_l > mag_r) ? mag_l : mag_r;
      resc <= status.resc_now;
    end
  end

  // Result register; rescaled thrusts take back the sign of the unscaled ones.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (resc) begin
        left_thrust <= left[24] ? 16'(-{1'b0, q_a}) : {1'b0, q_a};
        right_thrust <= right[24] ? 16'(-{1'b0, q_b}) : {1'b0, q_b};
      end else begin
        left_thrust <= left[15:0];
        right_thrust <= right[15:0];
      end
      base_saturated <= sat;
      rescaled <= resc;
    end
  end

  // The integrator never leaves its saturation range.
  a_base_range: assert property (@(posedge clk) disable iff (rst)
    (base >= dtvl_pkg::BASE_MIN) && (base <= dtvl_pkg::BASE_MAX))
    else $error("base thrust outside its limits");

endmodule

@@ rtl/dtvl_ctrl.sv @@
// Controller: sequences one transaction through the datapath and drives the handshakes.
`timescale 1ns / 1ps

module dtvl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  dtvl_pkg::status_t   status,
  output dtvl_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_NORM_INIT,
    S_NORM_DIV,
    S_NORM_FIN,
    S_MUL,
    S_BASE,
    S_MIX,
    S_MAG,
    S_MAX,
    S_RESC_INIT,
    S_RESC_DIV,
    S_DONE
  } state_t;

  localparam logic [dtvl_pkg::DIV_CNT_W-1:0] CNT_LAST = dtvl_pkg::DIV_CNT_W'(dtvl_pkg::Q_W - 1);

  state_t                          state;
  state_t                          state_next;
  logic [dtvl_pkg::DIV_CNT_W-1:0]  cnt;
  logic                            out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Command decode and next state.
  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_NORM_INIT;
        end
      end
      S_NORM_INIT: begin
        cmd.norm_init = 1'b1;
        state_next = S_NORM_DIV;
      end
      S_NORM_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = S_NORM_FIN;
        end
      end
      S_NORM_FIN: begin
        cmd.norm_fin = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_surge = 1'b1;
        state_next = S_BASE;
      end
      S_BASE: begin
        cmd.base_upd = 1'b1;
        cmd.mul_yaw = 1'b1;
        state_next = S_MIX;
      end
      S_MIX: begin
        cmd.mix = 1'b1;
        state_next = S_MAG;
      end
      S_MAG: begin
        cmd.mag = 1'b1;
        state_next = S_MAX;
      end
      S_MAX: begin
        cmd.pick_max = 1'b1;
        state_next = status.resc_now ? S_RESC_INIT : S_DONE;
      end
      S_RESC_INIT: begin
        cmd.resc_init = 1'b1;
        state_next = S_RESC_DIV;
      end
      S_RESC_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, divider step count and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.div_step) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A held result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result register loaded while a stalled result waits");

  // An accepted transaction starts normalization on the next cycle.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_NORM_INIT))
    else $error("accepted transaction did not start");

  // A new result appears only after the finishing state.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result valid raised outside the finishing state");

endmodule

@@ rtl/differential_thrust_velocity_loop.sv @@
// Top level: register file, controller and datapath of the differential thrust velocity loop.
`timescale 1ns / 1ps

// Each accepted transaction carries target and measured surge and yaw velocities and
// yields one result with the left and right thrust commands, the base saturation flag
// and the rescale flag. Transactions are handled one at a time: the block accepts no new
// item until the last one's result has been loaded into the result register, which can
// wait on out_stall. The two restoring divider lanes, 15 quotient bits each, run once
// for the error normalization and once more for the rescaling pass when
// the thrusts need rescaling. A finished result waits in its own register, so
// the next transaction is accepted while it is still held. Configuration registers sit
// at byte addresses 0, 4, 8, 12, 16 and 20 and are to be written only while idle.

module differential_thrust_velocity_loop (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] target_surge,
  input  logic signed [15:0] measured_surge,
  input  logic signed [15:0] target_yaw,
  input  logic signed [15:0] measured_yaw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] left_thrust,
  output logic signed [15:0] right_thrust,
  output logic               base_saturated,
  output logic               rescaled
);

  dtvl_pkg::cfg_t    cfg;
  dtvl_pkg::cmd_t    cmd;
  dtvl_pkg::status_t status;
  logic              wr;
  logic [2:0]        reg_idx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.surge_vel_limit <= 16'd256;
      cfg.yaw_vel_limit <= 16'd256;
      cfg.surge_clamp <= 15'd16384;
      cfg.yaw_clamp <= 15'd16384;
      cfg.surge_gain <= 16'd256;
      cfg.yaw_gain <= 16'd256;
    end else if (wr) begin
      unique case (reg_idx)
        dtvl_pkg::REG_SURGE_VEL_LIMIT: cfg.surge_vel_limit <= pwdata[15:0];
        dtvl_pkg::REG_YAW_VEL_LIMIT: cfg.yaw_vel_limit <= pwdata[15:0];
        dtvl_pkg::REG_SURGE_CLAMP: cfg.surge_clamp <= pwdata[14:0];
        dtvl_pkg::REG_YAW_CLAMP: cfg.yaw_clamp <= pwdata[14:0];
        dtvl_pkg::REG_SURGE_GAIN: cfg.surge_gain <= pwdata[15:0];
        dtvl_pkg::REG_YAW_GAIN: cfg.yaw_gain <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Configuration register reads.
  always_comb begin
    unique case (reg_idx)
      dtvl_pkg::REG_SURGE_VEL_LIMIT: prdata = 32'(cfg.surge_vel_limit);
      dtvl_pkg::REG_YAW_VEL_LIMIT: prdata = 32'(cfg.yaw_vel_limit);
      dtvl_pkg::REG_SURGE_CLAMP: prdata = 32'(cfg.surge_clamp);
      dtvl_pkg::REG_YAW_CLAMP: prdata = 32'(cfg.yaw_clamp);
      dtvl_pkg::REG_SURGE_GAIN: prdata = 32'(cfg.surge_gain);
      dtvl_pkg::REG_YAW_GAIN: prdata = 32'(cfg.yaw_gain);
      default: prdata = '0;
    endcase
  end

  dtvl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  dtvl_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .target_surge   (target_surge),
    .measured_surge (measured_surge),
    .target_yaw     (target_yaw),
    .measured_yaw   (measured_yaw),
    .left_thrust    (left_thrust),
    .right_thrust   (right_thrust),
    .base_saturated (base_saturated),
    .rescaled       (rescaled)
  );

endmodule
